/* hdl/ufsf_pkg.sv */
// shared constants and state type for the spanning-forest edge classifier
package ufsf_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned VERT_W           = 10;
  localparam int unsigned EDGE_ID_W        = 16;
  localparam int unsigned COUNT_W          = 11;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_RD,
    S_WALK,
    S_COMP,
    S_LINK,
    S_DONE
  } uf_state_t;

endpackage

/* hdl/union_find_spanning_forest.sv */
// spanning-forest edge classifier: disjoint-set parent memory with find, compress and link
// per edge word: a find on each endpoint, then a link; an out-of-range edge skips the finds
//   and the link; one edge at a time; in the parent memory each find step is one registered read,
//   each compression step one read plus one write
// first_edge adds a fill sweep over the first min(vertex_count, MAX_VERTICES) entries before the walk
// after rst: sweep over all MAX_VERTICES memory entries with edge_stall high, vertex_count at 1024
module union_find_spanning_forest #(
  parameter int unsigned MAX_VERTICES = ufsf_pkg::MAX_VERTICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel (vertex_count)
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ufsf_pkg::COUNT_W-1:0]     cfg_data,
  // edge words in
  input  logic                             edge_valid,
  output logic                             edge_stall,
  input  logic [ufsf_pkg::EDGE_ID_W-1:0]   edge_id,
  input  logic [ufsf_pkg::VERT_W-1:0]      vert_a,
  input  logic [ufsf_pkg::VERT_W-1:0]      vert_b,
  input  logic                             first_edge,
  // result words out
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [ufsf_pkg::EDGE_ID_W-1:0]   edge_id_out,
  output logic                             in_forest,
  output logic                             range_error
);

  // address width of the parent memory, and compare widths
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int XW  = (AW > int'(ufsf_pkg::VERT_W)) ? AW : int'(ufsf_pkg::VERT_W);
  localparam int LW  = $clog2(MAX_VERTICES + 1);
  localparam int CW0 = (LW > int'(ufsf_pkg::COUNT_W)) ? LW : int'(ufsf_pkg::COUNT_W);
  localparam int CW  = (CW0 > int'(ufsf_pkg::VERT_W)) ? CW0 : int'(ufsf_pkg::VERT_W);

  // parent memory, registered read
  logic [AW-1:0] parent_mem [MAX_VERTICES];
  logic [AW-1:0] rdata;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_wdata;

  // control and working registers
  ufsf_pkg::uf_state_t state, state_next;
  logic [ufsf_pkg::COUNT_W-1:0]   vertex_count;
  logic [AW-1:0]                  cur, cur_next;        // walk pointer, also fill counter
  logic [AW-1:0]                  start, start_next;    // endpoint the current find began at
  logic [AW-1:0]                  root, root_next;      // root of the current find
  logic [AW-1:0]                  ra, ra_next;          // root of vert_a
  logic                           phase, phase_next;    // 0: finding vert_a, 1: vert_b
  logic [AW-1:0]                  fill_last, fill_last_next;
  logic                           fill_item, fill_item_next; // sweep belongs to an edge
  logic                           forest, forest_next;
  logic                           err, err_next;
  logic [ufsf_pkg::EDGE_ID_W-1:0] eid, eid_next;
  logic [AW-1:0]                  va, va_next;
  logic [AW-1:0]                  vb, vb_next;

  logic          find_done;
  logic [AW-1:0] found_root;
  logic          out_free;

  // endpoint compare against the effective vertex count
  logic [CW-1:0] vc_ext;
  logic [CW-1:0] max_ext;
  logic [CW-1:0] lim;
  logic          in_err;
  logic [AW-1:0] a_idx;
  logic [AW-1:0] b_idx;

  assign vc_ext  = CW'(vertex_count);
  assign max_ext = CW'(MAX_VERTICES);
  assign lim     = (vc_ext < max_ext) ? vc_ext : max_ext;
  assign in_err  = (CW'(vert_a) >= lim) || (CW'(vert_b) >= lim);
  // in-range endpoints always fit the address width
  assign a_idx   = AW'(XW'(vert_a));
  assign b_idx   = AW'(XW'(vert_b));

  assign cfg_ready  = 1'b1;
  assign edge_stall = (state != ufsf_pkg::S_IDLE);
  // output register frees up when empty or being taken this cycle
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      parent_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= parent_mem[rd_addr];
  end

  // sequencer: fill sweep, two finds with compression, link, result hand-off
  always_comb begin
    state_next     = state;
    cur_next       = cur;
    start_next     = start;
    root_next      = root;
    ra_next        = ra;
    phase_next     = phase;
    fill_last_next = fill_last;
    fill_item_next = fill_item;
    forest_next    = forest;
    err_next       = err;
    eid_next       = eid;
    va_next        = va;
    vb_next        = vb;
    rd_addr        = cur;
    mem_we         = 1'b0;
    mem_waddr      = cur;
    mem_wdata      = cur;
    find_done      = 1'b0;
    found_root     = root;

    case (state)
      ufsf_pkg::S_FILL: begin
        // every swept entry points at itself
        mem_we = 1'b1;
        if (cur == fill_last) begin
          cur_next   = va;
          start_next = va;
          phase_next = 1'b0;
          if (!fill_item) begin
            state_next = ufsf_pkg::S_IDLE;
          end else if (err) begin
            state_next = ufsf_pkg::S_DONE;
          end else begin
            state_next = ufsf_pkg::S_RD;
          end
        end else begin
          cur_next = cur + 1'b1;
        end
      end
      ufsf_pkg::S_IDLE: begin
        if (edge_valid) begin
          eid_next       = edge_id;
          va_next        = a_idx;
          vb_next        = b_idx;
          err_next       = in_err;
          forest_next    = 1'b0;
          phase_next     = 1'b0;
          cur_next       = a_idx;
          start_next     = a_idx;
          if (first_edge && (lim != '0)) begin
            cur_next       = '0;
            fill_last_next = AW'(lim - CW'(1));
            fill_item_next = 1'b1;
            state_next     = ufsf_pkg::S_FILL;
          end else if (in_err) begin
            state_next = ufsf_pkg::S_DONE;
          end else begin
            state_next = ufsf_pkg::S_RD;
          end
        end
      end
      ufsf_pkg::S_RD: begin
        state_next = ufsf_pkg::S_WALK;
      end
      ufsf_pkg::S_WALK: begin
        // rdata is the parent of cur
        if (rdata == cur) begin
          found_root = cur;
          root_next  = cur;
          if (cur == start) begin
            find_done = 1'b1;
          end else begin
            // restart at the endpoint and point every node on the path at the root
            cur_next   = start;
            rd_addr    = start;
            state_next = ufsf_pkg::S_COMP;
          end
        end else begin
          cur_next = rdata;
          rd_addr  = rdata;
        end
      end
      ufsf_pkg::S_COMP: begin
        mem_we    = 1'b1;
        mem_wdata = root;
        if (rdata == root) begin
          find_done = 1'b1;
        end else begin
          cur_next = rdata;
          rd_addr  = rdata;
        end
      end
      ufsf_pkg::S_LINK: begin
        // root holds the root of vert_b here
        forest_next = (ra != root);
        if (ra != root) begin
          mem_we    = 1'b1;
          mem_waddr = ra;
          mem_wdata = root;
        end
        state_next = ufsf_pkg::S_DONE;
      end
      ufsf_pkg::S_DONE: begin
        if (out_free) begin
          state_next = ufsf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ufsf_pkg::S_IDLE;
      end
    endcase

    if (find_done) begin
      if (!phase) begin
        ra_next    = found_root;
        phase_next = 1'b1;
        cur_next   = vb;
        start_next = vb;
        state_next = ufsf_pkg::S_RD;
      end else begin
        state_next = ufsf_pkg::S_LINK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ufsf_pkg::S_FILL;
      cur          <= '0;
      fill_last    <= AW'(MAX_VERTICES - 1);
      fill_item    <= 1'b0;
      vertex_count <= ufsf_pkg::COUNT_RESET;
      result_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      fill_last <= fill_last_next;
      fill_item <= fill_item_next;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if ((state == ufsf_pkg::S_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    start  <= start_next;
    root   <= root_next;
    ra     <= ra_next;
    phase  <= phase_next;
    forest <= forest_next;
    err    <= err_next;
    eid    <= eid_next;
    va     <= va_next;
    vb     <= vb_next;
    if ((state == ufsf_pkg::S_DONE) && out_free) begin
      edge_id_out <= eid;
      in_forest   <= forest;
      range_error <= err;
    end
  end

  // an accepted edge always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    edge_valid && !edge_stall |=> state != ufsf_pkg::S_IDLE)
    else $error("accepted edge word left the sequencer idle");

  // an out-of-range edge never counts as a forest edge
  a_err_not_forest: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(in_forest && range_error))
    else $error("result flagged both forest edge and range error");

  // compression write never lands on the address read in the same cycle
  a_comp_hazard: assert property (@(posedge clk) disable iff (rst)
    state == ufsf_pkg::S_COMP && rdata != root |-> rd_addr != mem_waddr)
    else $error("compression write collides with next read");

  // a link only joins two distinct roots
  a_link_distinct: assert property (@(posedge clk) disable iff (rst)
    state == ufsf_pkg::S_LINK && mem_we |-> ra != root && mem_waddr == ra)
    else $error("link written between equal roots");

endmodule

/* sim/testbench.sv */
// self-checking testbench for the spanning-forest edge classifier
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NV          = ufsf_pkg::MAX_VERTICES_DEF;
  // worst single edge: a full fill sweep plus two walks over a degenerate chain,
  // plus the result-side hold-off, taken several times over
  localparam int          QUIET_LIMIT = 40000;
  localparam int          HOLDOFF     = 400;
  localparam int          RANDOM_ITEMS = 1850;

  // one edge word as offered to the block
  typedef struct packed {
    logic [ufsf_pkg::EDGE_ID_W-1:0] eid;
    logic [ufsf_pkg::VERT_W-1:0]    a;
    logic [ufsf_pkg::VERT_W-1:0]    b;
    logic                           first;
  } edge_t;

  // one result word as the block should return it
  typedef struct packed {
    logic [ufsf_pkg::EDGE_ID_W-1:0] eid;
    logic                           forest;
    logic                           err;
  } verdict_t;

  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           cfg_valid    = 1'b0;
  logic                           cfg_ready;
  logic [ufsf_pkg::COUNT_W-1:0]   cfg_data     = '0;
  logic                           edge_valid   = 1'b0;
  logic                           edge_stall;
  logic [ufsf_pkg::EDGE_ID_W-1:0] edge_id      = '0;
  logic [ufsf_pkg::VERT_W-1:0]    vert_a       = '0;
  logic [ufsf_pkg::VERT_W-1:0]    vert_b       = '0;
  logic                           first_edge   = 1'b0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic [ufsf_pkg::EDGE_ID_W-1:0] edge_id_out;
  logic                           in_forest;
  logic                           range_error;

  // predictor state: our own disjoint-set table and vertex count
  logic [ufsf_pkg::VERT_W-1:0]  link_tab [NV];
  logic [ufsf_pkg::COUNT_W-1:0] vcount_model;

  edge_t    edge_backlog [$];   // edge words waiting to be offered
  verdict_t verdict_q    [$];   // classifications still owed by the block

  int errors       = 0;
  int edges_taken  = 0;
  int results_seen = 0;
  int forest_seen  = 0;
  int cycle_seen   = 0;
  int error_seen   = 0;
  int cfg_writes   = 0;
  int hold_left    = 0;
  bit holdoff_done = 1'b0;
  int quiet        = 0;

  // vertex_count settings walked by the random part before it draws random counts
  logic [ufsf_pkg::COUNT_W-1:0] count_menu [0:13] = '{
    11'd2, 11'd1024, 11'd3, 11'd40, 11'd2047, 11'd1, 11'd300,
    11'd1024, 11'd0, 11'd16, 11'd1025, 11'd700, 11'd5, 11'd1024
  };

  union_find_spanning_forest #(
    .MAX_VERTICES(ufsf_pkg::MAX_VERTICES_DEF)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .edge_valid  (edge_valid),
    .edge_stall  (edge_stall),
    .edge_id     (edge_id),
    .vert_a      (vert_a),
    .vert_b      (vert_b),
    .first_edge  (first_edge),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .edge_id_out (edge_id_out),
    .in_forest   (in_forest),
    .range_error (range_error)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // root lookup with full path compression on the predictor table
  function automatic logic [ufsf_pkg::VERT_W-1:0] root_of(logic [ufsf_pkg::VERT_W-1:0] v);
    logic [ufsf_pkg::VERT_W-1:0] r;
    logic [ufsf_pkg::VERT_W-1:0] cur;
    logic [ufsf_pkg::VERT_W-1:0] nxt;
    int                          steps;
    r = v;
    steps = 0;
    while (link_tab[r] != r && steps < NV) begin
      r = link_tab[r];
      steps++;
    end
    cur = v;
    steps = 0;
    while (cur != r && steps < NV) begin
      nxt = link_tab[cur];
      link_tab[cur] = r;
      cur = nxt;
      steps++;
    end
    return r;
  endfunction

  // classify one accepted edge word and update the predictor table
  function automatic verdict_t classify_edge(edge_t e);
    verdict_t                    v;
    int unsigned                 lim;
    logic [ufsf_pkg::VERT_W-1:0] ra;
    logic [ufsf_pkg::VERT_W-1:0] rb;
    lim = (vcount_model < NV) ? vcount_model : NV;
    if (e.first) begin
      for (int unsigned i = 0; i < lim; i++) link_tab[i] = ufsf_pkg::VERT_W'(i);
    end
    v.eid    = e.eid;
    v.forest = 1'b0;
    v.err    = 1'b0;
    if (e.a >= lim || e.b >= lim) begin
      // out-of-range endpoint: no walk, no link
      v.err = 1'b1;
    end else begin
      ra = root_of(e.a);
      rb = root_of(e.b);
      if (ra != rb) begin
        link_tab[ra] = rb;
        v.forest = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic edge_t mk_edge(logic [ufsf_pkg::EDGE_ID_W-1:0] id,
                                    logic [ufsf_pkg::VERT_W-1:0] a,
                                    logic [ufsf_pkg::VERT_W-1:0] b, logic first);
    edge_t e;
    e.eid   = id;
    e.a     = a;
    e.b     = b;
    e.first = first;
    return e;
  endfunction

  // append one edge word to the backlog
  function automatic void add_edge(edge_t e);
    edge_backlog.insert(edge_backlog.size(), e);
  endfunction

  // mostly in-range endpoints, with some raw 10-bit noise
  function automatic logic [ufsf_pkg::VERT_W-1:0] pick_vertex(int unsigned lim);
    if (lim == 0 || $urandom_range(0, 99) < 5) return ufsf_pkg::VERT_W'($urandom);
    return ufsf_pkg::VERT_W'($urandom_range(0, lim - 1));
  endfunction

  // write vertex_count through the config channel, block idle
  task automatic write_count(logic [ufsf_pkg::COUNT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid    <= 1'b0;
    vcount_model = value;
    cfg_writes++;
    @(negedge clk);
  endtask

  // wait until every queued edge has gone in and every verdict has come back
  task automatic settle();
    do @(negedge clk);
    while (edge_backlog.size() != 0 || edge_valid || verdict_q.size() != 0);
  endtask

  // edge driver: offers backlog words, predicts each one at acceptance
  always @(posedge clk) begin : drive_edges
    logic     nxt_valid;
    logic     calm;
    edge_t    nxt;
    verdict_t got;
    nxt_valid = edge_valid;
    nxt       = mk_edge(edge_id, vert_a, vert_b, first_edge);
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (edge_valid && edge_stall === 1'b0) begin
        got = classify_edge(mk_edge(edge_id, vert_a, vert_b, first_edge));
        verdict_q.insert(verdict_q.size(), got);
        edges_taken++;
        nxt_valid = 1'b0;
      end
      // a held word stays put; a new one goes out unless this cycle idles
      if (!nxt_valid && edge_backlog.size() != 0) begin
        calm = (edges_taken >= 600 && edges_taken < 900);
        if (calm || $urandom_range(0, 99) >= 15) begin
          nxt       = edge_backlog.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    edge_valid <= nxt_valid;
    edge_id    <= nxt.eid;
    vert_a     <= nxt.a;
    vert_b     <= nxt.b;
    first_edge <= nxt.first;
  end

  // result monitor: checks each accepted word against the oldest verdict
  always @(posedge clk) begin : check_results
    verdict_t want;
    logic     nxt_stall;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      results_seen++;
      if (in_forest === 1'b1) forest_seen++;
      if (range_error === 1'b1) error_seen++;
      else if (in_forest === 1'b0) cycle_seen++;
      if (verdict_q.size() == 0) begin
        $error("result word with no edge pending: edge_id_out %0d", edge_id_out);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (edge_id_out !== want.eid) begin
          $error("edge_id_out: expected %0d, got %0d", want.eid, edge_id_out);
          errors++;
        end
        if (in_forest !== want.forest) begin
          $error("in_forest: expected %0b, got %0b (edge %0d)", want.forest, in_forest,
                 want.eid);
          errors++;
        end
        if (range_error !== want.err) begin
          $error("range_error: expected %0b, got %0b (edge %0d)", want.err, range_error,
                 want.eid);
          errors++;
        end
      end
    end
    // stall pattern: one long hold-off, a calm stretch, random idling elsewhere
    if (rst) begin
      nxt_stall = 1'b0;
    end else if (hold_left > 0) begin
      nxt_stall = 1'b1;
      hold_left--;
    end else if (!holdoff_done && results_seen >= 1200) begin
      holdoff_done = 1'b1;
      hold_left    = HOLDOFF - 1;
      nxt_stall    = 1'b1;
    end else if (results_seen >= 600 && results_seen < 900) begin
      nxt_stall = 1'b0;
    end else begin
      nxt_stall = ($urandom_range(0, 99) < 15);
    end
    result_stall <= nxt_stall;
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin : watchdog
    if (rst || (edge_valid && edge_stall === 1'b0) ||
        (result_valid === 1'b1 && result_stall === 1'b0) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int                           p;
    int                           k;
    int                           left;
    int                           phase_len;
    int                           random_total;
    int unsigned                  lim;
    logic [ufsf_pkg::COUNT_W-1:0] cnt;
    logic [ufsf_pkg::VERT_W-1:0]  a;
    logic [ufsf_pkg::VERT_W-1:0]  b;
    logic                         fresh;

    for (int unsigned i = 0; i < NV; i++) link_tab[i] = ufsf_pkg::VERT_W'(i);
    vcount_model = ufsf_pkg::COUNT_RESET;
    random_total = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // full count: extreme ids and vertices, self loop, a chain that gets compressed
    write_count(11'd1024);
    add_edge(mk_edge(16'd0, 10'd0, 10'd1023, 1'b1));
    add_edge(mk_edge(16'd65535, 10'd1023, 10'd0, 1'b0));
    add_edge(mk_edge(16'd1, 10'd5, 10'd5, 1'b0));
    add_edge(mk_edge(16'd2, 10'd1, 10'd2, 1'b0));
    add_edge(mk_edge(16'd3, 10'd2, 10'd3, 1'b0));
    add_edge(mk_edge(16'd4, 10'd3, 10'd4, 1'b0));
    add_edge(mk_edge(16'd5, 10'd1, 10'd4, 1'b0));
    add_edge(mk_edge(16'd6, 10'd4, 10'd0, 1'b0));
    settle();

    // smallest count: in-range walk leaves the active range, range errors,
    // a first edge that still resets on an error
    write_count(11'd1);
    add_edge(mk_edge(16'd7, 10'd0, 10'd0, 1'b0));
    add_edge(mk_edge(16'd8, 10'd0, 10'd1, 1'b0));
    add_edge(mk_edge(16'd9, 10'd1023, 10'd1023, 1'b1));
    add_edge(mk_edge(16'd10, 10'd0, 10'd0, 1'b0));
    settle();

    // zero count: everything is a range error
    write_count(11'd0);
    add_edge(mk_edge(16'd11, 10'd0, 10'd0, 1'b1));
    add_edge(mk_edge(16'd12, 10'd1023, 10'd512, 1'b0));
    settle();

    // count above the table size, old sets above the shrunk range still linked
    write_count(11'd2047);
    add_edge(mk_edge(16'd13, 10'd1, 10'd1023, 1'b0));
    add_edge(mk_edge(16'd14, 10'd1023, 10'd1022, 1'b0));
    add_edge(mk_edge(16'hAAAA, 10'h2AA, 10'h155, 1'b0));
    add_edge(mk_edge(16'h5555, 10'h155, 10'h2AA, 1'b0));
    add_edge(mk_edge(16'd16, 10'd7, 10'd8, 1'b1));
    add_edge(mk_edge(16'd17, 10'd1, 10'd1023, 1'b0));
    settle();

    // random phases: graph sessions opened by a first edge, random content,
    // some sessions left open across phases and some stray first edges
    p = 0;
    while (random_total < RANDOM_ITEMS) begin
      cnt = (p < 14) ? count_menu[p] : ufsf_pkg::COUNT_W'($urandom_range(1, 1024));
      write_count(cnt);
      lim       = (cnt < NV) ? cnt : NV;
      phase_len = $urandom_range(100, 170);
      left      = 0;
      for (k = 0; k < phase_len; k++) begin
        fresh = 1'b0;
        if (left == 0) begin
          left  = (lim <= 64) ? $urandom_range(4, 3 * lim + 4) : $urandom_range(40, 250);
          fresh = (k != 0) || ($urandom_range(0, 3) != 0);
        end
        left--;
        // cheap extra resets on small tables
        if (lim <= 64 && $urandom_range(0, 99) < 2) fresh = 1'b1;
        a = pick_vertex(lim);
        b = pick_vertex(lim);
        add_edge(mk_edge(ufsf_pkg::EDGE_ID_W'($urandom), a, b, fresh));
      end
      random_total += phase_len;
      settle();
      p++;
    end

    // drain: give any stray word time to show up
    repeat (64) @(posedge clk);

    $display("ran %0d edge words over %0d vertex_count writes, %0d-cycle result hold-off",
             edges_taken, cfg_writes, HOLDOFF);
    $display("classified %0d forest, %0d cycle, %0d range-error edges",
             forest_seen, cycle_seen, error_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* union_find_spanning_forest.f */
hdl/ufsf_pkg.sv
hdl/union_find_spanning_forest.sv
sim/testbench.sv
